// File: design/tws_pkg.sv
package tws_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int AW   = XW + YW;
  localparam int DIMW = 9;
  localparam int CNTW = AW + 1;
  localparam logic [15:0] GRAD_OUTSIDE = 16'hFFFF;
  localparam logic [16:0] W_STRAIGHT = 17'd65536;
  localparam logic [16:0] W_DIAG     = 17'd46341;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LINES  = 2'd2;

  typedef logic [AW-1:0] addr_t;

  function automatic logic signed [2:0] step_dx(input logic [2:0] n);
    unique case (n)
      3'd0, 3'd1, 3'd2: step_dx = 3'sd1;
      3'd3, 3'd4:       step_dx = 3'sd0;
      default:          step_dx = -3'sd1;
    endcase
  endfunction

  function automatic logic signed [2:0] step_dy(input logic [2:0] n);
    unique case (n)
      3'd0, 3'd3, 3'd5: step_dy = 3'sd1;
      3'd1, 3'd6:       step_dy = 3'sd0;
      default:          step_dy = -3'sd1;
    endcase
  endfunction

  function automatic addr_t pos(input logic [XW-1:0] x, input logic [YW-1:0] y);
    pos = {y, x};
  endfunction
endpackage

// File: design/toboggan_watershed_segmenter.sv
// Channel | Dir | Fields
// in_     | in  | tuser: kind; tdata: pixel_in
// out_    | out | tdata: pixel_out; tlast: last_pixel
// cfg_    | in  | index 0 width, 1 height, 2 show_lines
// Loading writes each pixel, then passes a wait state before the next.
// After the last pixel: clear sweep of all MAX_WIDTH*MAX_HEIGHT visited flags,
// Sobel pass (9 reads and a square root per pixel),
// descent over 8 neighbours per path pixel, relabel of each path pixel.
// Readout makes three label reads a pixel. Reset is synchronous.
// Input is held off in processing passes and while a result waits mid-readout.
module toboggan_watershed_segmenter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] pixel_in
  input  logic       in_tuser,   // [0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] pixel_out
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);
  import tws_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_LOADW = 5'd1,  S_CLR = 5'd2,
    S_GRD = 5'd3, S_GRDW = 5'd4, S_GSQ = 5'd5, S_GRT = 5'd6,
    S_SEGI = 5'd7, S_SEGV = 5'd8, S_DC = 5'd9, S_DCW = 5'd10,
    S_DN = 5'd11, S_DNW = 5'd12, S_DMV = 5'd13, S_DVW = 5'd14,
    S_DVC = 5'd15, S_COL = 5'd16, S_COLW = 5'd17, S_REL = 5'd18,
    S_RELW = 5'd19, S_RD = 5'd20, S_RDW = 5'd21, S_OUT = 5'd22,
    S_NEXT = 5'd23, S_RDY = 5'd24;

  logic [4:0] st_r, st_nxt;
  logic [DIMW-1:0] wcfg_r, hcfg_r;
  logic lines_r;
  logic [XW:0] w;
  logic [YW:0] h;
  logic [CNTW-1:0] total;

  always_comb begin
    w = (wcfg_r == 0) ? (XW+1)'(1) :
        (wcfg_r > DIMW'(MAX_WIDTH)) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(wcfg_r);
    h = (hcfg_r == 0) ? (YW+1)'(1) :
        (hcfg_r > DIMW'(MAX_HEIGHT)) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(hcfg_r);
    total = CNTW'(w) * CNTW'(h);
  end

  // memories
  logic pwe, gwe, vwe, swe;
  addr_t pwa, pra, gwa, gra, vwa, vra, swa, sra, swd;
  logic [7:0] pwd, prd;
  logic [15:0] gwd, grd;
  logic vwd, vrd;
  addr_t srd;

  tws_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_pix (.clk, .we(pwe), .waddr(pwa),
    .wdata(pwd), .raddr(pra), .rdata(prd));
  tws_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_grad (.clk, .we(gwe), .waddr(gwa),
    .wdata(gwd), .raddr(gra), .rdata(grd));
  tws_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_vis (.clk, .we(vwe), .waddr(vwa),
    .wdata(vwd), .raddr(vra), .rdata(vrd));
  tws_ram #(.WIDTH(AW), .DEPTH(1 << AW)) u_stk (.clk, .we(swe), .waddr(swa),
    .wdata(swd), .raddr(sra), .rdata(srd));

  logic sq_start, sq_done;
  logic [31:0] sq_val;
  logic [15:0] sq_root;
  tws_isqrt u_sqrt (.clk, .rst_n, .start(sq_start), .value(sq_val),
    .done(sq_done), .root(sq_root));

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [XW:0] lx_r, lx_nxt, i_r, i_nxt;
  logic [YW:0] ly_r, ly_nxt, j_r, j_nxt;
  logic [XW:0] cx_r, cx_nxt;
  logic [YW:0] cy_r, cy_nxt;
  logic [3:0] k_r, k_nxt;
  logic signed [12:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [15:0] g_r, g_nxt;
  logic signed [34:0] best_r, best_nxt;
  logic [2:0] bn_r, bn_nxt;
  logic lower_r, lower_nxt;
  logic [CNTW-1:0] sp_r, sp_nxt;
  logic [7:0] col_r, col_nxt, lab_r, lab_nxt;
  logic diff_r, diff_nxt;
  logic [7:0] od_r, od_nxt;
  logic ov_r, ov_nxt, ol_r, ol_nxt;

  logic in_acc, out_acc;
  assign in_acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (st_r == S_IDLE || (st_r == S_RDY && !ov_r)) && !cfg_we;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

  // neighbour helpers
  logic signed [XW+2:0] nx;
  logic signed [YW+2:0] ny;
  logic n_in;
  logic [XW-1:0] ncx;
  logic [YW-1:0] ncy;
  logic [2:0] kk;
  logic signed [16:0] diff;
  logic signed [34:0] score;
  logic [31:0] ssum;
  logic signed [31:0] sxe, sye;
  logic signed [12:0] pv, cxk, cyk;
  logic signed [2:0] ox, oy;

  always_comb begin
    kk = k_r[2:0];
    pv = $signed({5'b0, prd});
    // Sobel tap order k=0..8 row-major over (-1..1)
    unique case (k_r)
      4'd0: begin cxk = -13'sd1; cyk = -13'sd1; ox = -3'sd1; oy = -3'sd1; end
      4'd1: begin cxk = 13'sd0;  cyk = -13'sd2; ox = 3'sd0;  oy = -3'sd1; end
      4'd2: begin cxk = 13'sd1;  cyk = -13'sd1; ox = 3'sd1;  oy = -3'sd1; end
      4'd3: begin cxk = -13'sd2; cyk = 13'sd0;  ox = -3'sd1; oy = 3'sd0;  end
      4'd5: begin cxk = 13'sd2;  cyk = 13'sd0;  ox = 3'sd1;  oy = 3'sd0;  end
      4'd6: begin cxk = -13'sd1; cyk = 13'sd1;  ox = -3'sd1; oy = 3'sd1;  end
      4'd7: begin cxk = 13'sd0;  cyk = 13'sd2;  ox = 3'sd0;  oy = 3'sd1;  end
      4'd8: begin cxk = 13'sd1;  cyk = 13'sd1;  ox = 3'sd1;  oy = 3'sd1;  end
      default: begin cxk = 13'sd0; cyk = 13'sd0; ox = 3'sd0; oy = 3'sd0; end
    endcase
    if (st_r == S_GRD || st_r == S_GRDW) begin
      nx = $signed({2'b0, cx_r}) + (XW+3)'(ox);
      ny = $signed({2'b0, cy_r}) + (YW+3)'(oy);
    end else begin
      nx = $signed({2'b0, cx_r}) + (XW+3)'(step_dx(kk));
      ny = $signed({2'b0, cy_r}) + (YW+3)'(step_dy(kk));
    end
    n_in = nx >= 0 && ny >= 0 && nx < $signed({2'b0, w}) && ny < $signed({2'b0, h});
    ncx = (nx < 0) ? '0 : (nx > $signed({2'b0, w}) - 1) ? XW'(w - 1) : nx[XW-1:0];
    ncy = (ny < 0) ? '0 : (ny > $signed({2'b0, h}) - 1) ? YW'(h - 1) : ny[YW-1:0];
    sxe = 32'(sx_r);
    sye = 32'(sy_r);
    ssum = $unsigned(sxe * sxe + sye * sye);
  end

  logic [15:0] gn;
  always_comb begin
    gn = n_in ? grd : GRAD_OUTSIDE;
    diff = $signed({1'b0, gn}) - $signed({1'b0, g_r});
    score = diff * $signed({1'b0, ((step_dx(kk) != 0 && step_dy(kk) != 0) ?
      W_DIAG : W_STRAIGHT)});
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r; lx_nxt = lx_r; ly_nxt = ly_r; i_nxt = i_r; j_nxt = j_r;
    cx_nxt = cx_r; cy_nxt = cy_r; k_nxt = k_r; sx_nxt = sx_r; sy_nxt = sy_r;
    g_nxt = g_r; best_nxt = best_r; bn_nxt = bn_r; lower_nxt = lower_r;
    sp_nxt = sp_r; col_nxt = col_r; lab_nxt = lab_r; diff_nxt = diff_r;
    od_nxt = od_r; ov_nxt = ov_r && !out_tready; ol_nxt = ol_r;
    pwe = 1'b0; pwa = '0; pwd = '0; pra = pos(ncx, ncy);
    gwe = 1'b0; gwa = pos(cx_r[XW-1:0], cy_r[YW-1:0]); gwd = sq_root;
    gra = pos(nx[XW-1:0], ny[YW-1:0]);
    vwe = 1'b0; vwa = pos(cx_r[XW-1:0], cy_r[YW-1:0]); vwd = 1'b1;
    vra = pos(cx_r[XW-1:0], cy_r[YW-1:0]);
    swe = 1'b0; swa = sp_r[AW-1:0]; swd = pos(cx_r[XW-1:0], cy_r[YW-1:0]);
    sra = cnt_r[AW-1:0];
    sq_start = 1'b0; sq_val = ssum << 10;
    unique case (st_r)
      S_IDLE, S_RDY: begin
        if (in_acc) begin
          if (!in_tuser) begin
            if (st_r == S_RDY || cnt_r >= total) begin
              lx_nxt = '0; ly_nxt = '0; cnt_nxt = '0;
            end
            st_nxt = S_LOADW;
            pwe = 1'b1;
            pwa = (st_r == S_RDY || cnt_r >= total) ? '0 :
              pos(lx_r[XW-1:0], ly_r[YW-1:0]);
            pwd = in_tdata;
          end else if (st_r == S_RDY && !ov_r) begin
            st_nxt = S_RD; k_nxt = '0;
          end
        end
      end
      S_LOADW: begin
        cnt_nxt = cnt_r + 1;
        if (lx_r + 1 == w) begin lx_nxt = '0; ly_nxt = ly_r + 1; end
        else lx_nxt = lx_r + 1;
        if (cnt_r + 1 == total) begin st_nxt = S_CLR; cnt_nxt = '0; end
        else st_nxt = S_IDLE;
      end
      S_CLR: begin
        vwe = 1'b1; vwa = cnt_r[AW-1:0]; vwd = 1'b0;
        cnt_nxt = cnt_r + 1;
        if (cnt_r == CNTW'((1 << AW) - 1)) begin
          st_nxt = S_GRD; cx_nxt = '0; cy_nxt = '0; k_nxt = '0;
          sx_nxt = '0; sy_nxt = '0;
        end
      end
      S_GRD: st_nxt = S_GRDW;
      S_GRDW: begin
        sx_nxt = sx_r + pv * cxk;
        sy_nxt = sy_r + pv * cyk;
        if (k_r == 4'd8) st_nxt = S_GSQ;
        else begin k_nxt = k_r + 1; st_nxt = S_GRD; end
      end
      S_GSQ: begin sq_start = 1'b1; st_nxt = S_GRT; end
      S_GRT: if (sq_done) begin
        gwe = 1'b1;
        k_nxt = '0; sx_nxt = '0; sy_nxt = '0; st_nxt = S_GRD;
        if (cx_r + 1 == w) begin
          cx_nxt = '0;
          if (cy_r + 1 == h) begin st_nxt = S_SEGI; i_nxt = '0; j_nxt = '0; end
          else cy_nxt = cy_r + 1;
        end else cx_nxt = cx_r + 1;
      end
      S_SEGI: begin
        cx_nxt = i_r; cy_nxt = j_r; st_nxt = S_SEGV;
      end
      S_SEGV: st_nxt = S_DVW;
      S_DVW: begin
        if (vrd) begin
          if (j_r + 1 == h) begin
            j_nxt = '0;
            if (i_r + 1 == w) st_nxt = S_RDY;
            else begin i_nxt = i_r + 1; st_nxt = S_SEGI; end
          end else begin j_nxt = j_r + 1; st_nxt = S_SEGI; end
          if (st_nxt == S_RDY) begin cnt_nxt = '0; end
        end else begin
          swe = 1'b1; swa = '0; vwe = 1'b1; sp_nxt = CNTW'(1);
          st_nxt = S_DC;
        end
      end
      S_DC: begin gra = pos(cx_r[XW-1:0], cy_r[YW-1:0]); st_nxt = S_DCW; end
      S_DCW: begin
        g_nxt = grd; k_nxt = '0; lower_nxt = 1'b0; st_nxt = S_DN;
      end
      S_DN: st_nxt = S_DNW;
      S_DNW: begin
        if (gn < g_r) lower_nxt = 1'b1;
        if (k_r == 0 || score < best_r) begin best_nxt = score; bn_nxt = kk; end
        if (k_r == 4'd7) st_nxt = S_DMV;
        else begin k_nxt = k_r + 1; st_nxt = S_DN; end
      end
      S_DMV: begin
        if (lower_r) begin
          cx_nxt = (XW+1)'($signed({1'b0, cx_r}) + (XW+1)'(step_dx(bn_r)));
          cy_nxt = (YW+1)'($signed({1'b0, cy_r}) + (YW+1)'(step_dy(bn_r)));
        end
        st_nxt = S_DVC;
      end
      S_DVC: st_nxt = S_COL;
      S_COL: begin
        if (!vrd) begin
          if (sp_r < CNTW'(1 << AW)) begin swe = 1'b1; sp_nxt = sp_r + 1; end
          vwe = 1'b1; st_nxt = S_DC;
        end else begin
          st_nxt = S_COLW;
        end
        pra = pos(cx_r[XW-1:0], cy_r[YW-1:0]);
      end
      S_COLW: begin col_nxt = prd; cnt_nxt = '0; st_nxt = S_REL; end
      S_REL: st_nxt = S_RELW;
      S_RELW: begin
        pwe = 1'b1; pwa = srd; pwd = col_r;
        cnt_nxt = cnt_r + 1;
        if (cnt_r + 1 == sp_r) begin
          st_nxt = S_DVW; cx_nxt = i_r; cy_nxt = j_r;
          vra = pos(i_r[XW-1:0], j_r[YW-1:0]);
        end else st_nxt = S_REL;
      end
      S_RD: begin
        pra = (k_r == 0) ? pos(lx_r[XW-1:0], ly_r[YW-1:0]) :
              (k_r == 1) ? pos(XW'(lx_r + 1), ly_r[YW-1:0]) :
                           pos(lx_r[XW-1:0], YW'(ly_r + 1));
        st_nxt = S_RDW;
      end
      S_RDW: begin
        if (k_r == 0) begin lab_nxt = prd; diff_nxt = 1'b0; end
        else if (k_r == 1) diff_nxt = lx_r + 1 < w && prd != lab_r;
        else diff_nxt = diff_r || (ly_r + 1 < h && prd != lab_r);
        if (k_r == 2) st_nxt = S_OUT;
        else begin k_nxt = k_r + 1; st_nxt = S_RD; end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        od_nxt = (lines_r && diff_r) ? 8'd255 : lab_r;
        ol_nxt = cnt_r + 1 == total;
        cnt_nxt = cnt_r + 1;
        if (lx_r + 1 == w) begin lx_nxt = '0; ly_nxt = ly_r + 1; end
        else lx_nxt = lx_r + 1;
        if (cnt_r + 1 == total) begin
          st_nxt = S_IDLE; cnt_nxt = '0; lx_nxt = '0; ly_nxt = '0;
        end else st_nxt = S_RDY;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_SEGI) vra = pos(i_r[XW-1:0], j_r[YW-1:0]);
    if (st_r == S_CLR && st_nxt == S_GRD) begin lx_nxt = '0; ly_nxt = '0; end
    if (st_r == S_DVW && st_nxt == S_RDY) begin lx_nxt = '0; ly_nxt = '0; end
    if (cfg_we) begin
      st_nxt = S_IDLE; cnt_nxt = '0; lx_nxt = '0; ly_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      wcfg_r <= 9'd256; hcfg_r <= 9'd256; lines_r <= 1'b0;
      cnt_r <= '0; lx_r <= '0; ly_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; lx_r <= lx_nxt; ly_r <= ly_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:  wcfg_r <= cfg_wdata;
          CFG_HEIGHT: hcfg_r <= cfg_wdata;
          CFG_LINES:  lines_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    i_r <= i_nxt; j_r <= j_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt; k_r <= k_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; g_r <= g_nxt; best_r <= best_nxt;
    bn_r <= bn_nxt; lower_r <= lower_nxt; sp_r <= sp_nxt; col_r <= col_nxt;
    lab_r <= lab_nxt; diff_r <= diff_nxt;
    od_r <= od_nxt; ol_r <= ol_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CLR |-> !in_tready)
    else $error("input taken during clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_OUT |-> !out_tvalid)
    else $error("result overwritten");
endmodule

// File: design/tws_ram.sv
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/tws_isqrt.sv
module tws_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] value,
  output logic        done,
  output logic [15:0] root
);
  logic [31:0] v_r, v_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    v_nxt = v_r;
    r_nxt = r_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt = value;
      r_nxt = '0;
      bit_nxt = 32'h4000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= r_r + bit_r) begin
        v_nxt = v_r - (r_r + bit_r);
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 32'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r <= v_nxt;
    r_r <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[15:0];
endmodule

// File: dv/toboggan_watershed_segmenter_tb.sv
`timescale 1ns / 100ps

module toboggan_watershed_segmenter_tb;
  import tws_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam longint CYCLE_LIMIT = 8000000;

  class seg_scoreboard;
    bit [7:0]  pix [NPIX];
    bit [15:0] grad [NPIX];
    bit        seen [NPIX];
    int        path [$];
    bit [8:0]  reg_w, reg_h;
    bit        lines;
    int        load_pos, read_pos;
    bit        reading;
    bit        maybe_busy;
    bit [8:0]  expected_q [$];
    int        mismatches, results, images;

    function new();
      reg_w = 9'd256; reg_h = 9'd256; lines = 1'b0;
      load_pos = 0; read_pos = 0; reading = 1'b0; maybe_busy = 1'b0;
      mismatches = 0; results = 0; images = 0;
    endfunction

    function int eff_w();
      if (reg_w == 0) return 1;
      if (reg_w > MAX_WIDTH) return MAX_WIDTH;
      return reg_w;
    endfunction

    function int eff_h();
      if (reg_h == 0) return 1;
      if (reg_h > MAX_HEIGHT) return MAX_HEIGHT;
      return reg_h;
    endfunction

    function int at(int x, int y);
      return (y * MAX_WIDTH + x) % NPIX;
    endfunction

    function int clamped_pix(int x, int y, int w, int h);
      if (x < 0) x = 0;
      if (x > w - 1) x = w - 1;
      if (y < 0) y = 0;
      if (y > h - 1) y = h - 1;
      return pix[at(x, y)];
    endfunction

    function longint grad_or_wall(int x, int y, int w, int h);
      if (x < 0 || y < 0 || x >= w || y >= h) return 64'hFFFF;
      return grad[at(x, y)];
    endfunction

    function bit [15:0] int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r[15:0];
    endfunction

    function void sobel(int w, int h);
      int a, b, c, d, e, f, g, k, sx, sy;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          a = clamped_pix(x - 1, y - 1, w, h); b = clamped_pix(x, y - 1, w, h);
          c = clamped_pix(x + 1, y - 1, w, h); d = clamped_pix(x - 1, y, w, h);
          e = clamped_pix(x + 1, y, w, h);     f = clamped_pix(x - 1, y + 1, w, h);
          g = clamped_pix(x, y + 1, w, h);     k = clamped_pix(x + 1, y + 1, w, h);
          sx = -a + c - 2 * d + 2 * e - f + k;
          sy = -a - 2 * b - c + f + 2 * g + k;
          grad[at(x, y)] = int_sqrt(longint'(sx * sx + sy * sy) * 1024);
        end
    endfunction

    function void descend(int w, int h);
      int cx, cy, best, nx, ny;
      longint g, score, best_score, wt;
      bit lower;
      bit [7:0] colour;
      for (int n = 0; n < NPIX; n++) seen[n] = 1'b0;
      for (int i = 0; i < w; i++)
        for (int j = 0; j < h; j++) begin
          if (seen[at(i, j)]) continue;
          cx = i; cy = j;
          path.delete();
          path.push_back(at(cx, cy));
          seen[at(cx, cy)] = 1'b1;
          forever begin
            g = grad_or_wall(cx, cy, w, h);
            lower = 1'b0;
            for (int n = 0; n < 8; n++)
              if (grad_or_wall(cx + step_dx(n), cy + step_dy(n), w, h) < g) lower = 1'b1;
            if (lower) begin
              best = 0; best_score = 0;
              for (int n = 0; n < 8; n++) begin
                nx = cx + step_dx(n); ny = cy + step_dy(n);
                wt = (step_dx(n) != 0 && step_dy(n) != 0) ? 46341 : 65536;
                score = (grad_or_wall(nx, ny, w, h) - g) * wt;
                if (n == 0 || score < best_score) begin
                  best = n; best_score = score;
                end
              end
              cx += step_dx(best); cy += step_dy(best);
            end
            if (!seen[at(cx, cy)]) begin
              path.push_back(at(cx, cy));
              seen[at(cx, cy)] = 1'b1;
            end else begin
              break;
            end
          end
          colour = pix[at(cx, cy)];
          foreach (path[k]) pix[path[k]] = colour;
        end
    endfunction

    function void restart();
      reading = 1'b0; load_pos = 0; read_pos = 0;
    endfunction

    function void apply_reg(bit [1:0] idx, bit [8:0] val);
      if (idx == CFG_WIDTH) reg_w = val;
      else if (idx == CFG_HEIGHT) reg_h = val;
      else if (idx == CFG_LINES) lines = val[0];
      restart();
    endfunction

    function void note_transfer(bit kind, bit [7:0] pv);
      int w, h, total, x, y;
      bit [7:0] lab, res;
      bit last;
      w = eff_w(); h = eff_h(); total = w * h;
      if (kind == KIND_LOAD) begin
        if (reading) restart();
        if (load_pos >= total) load_pos = 0;
        pix[at(load_pos % w, load_pos / w)] = pv;
        load_pos++;
        if (load_pos == total) begin
          sobel(w, h);
          descend(w, h);
          reading = 1'b1; read_pos = 0; maybe_busy = 1'b1; images++;
        end
        return;
      end
      if (!reading || read_pos >= total) return;
      x = read_pos % w; y = read_pos / w;
      lab = pix[at(x, y)];
      res = lab;
      last = (read_pos + 1 == total);
      if (lines && ((x < w - 1 && lab != pix[at(x + 1, y)]) ||
                    (y < h - 1 && lab != pix[at(x, y + 1)])))
        res = 8'd255;
      expected_q.push_back({last, res});
      read_pos++;
      if (last) restart();
    endfunction

    function void check_output(bit [7:0] data, bit last);
      bit [8:0] exp_item;
      results++;
      maybe_busy = 1'b0;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer: data %0d last %0b", data, last);
        return;
      end
      exp_item = expected_q.pop_front();
      if (exp_item[7:0] !== data || exp_item[8] !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output %0d: expected data %0d last %0b, got data %0d last %0b",
                   results, exp_item[7:0], exp_item[8], data, last);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_wdata = '0;

  seg_scoreboard sb = new();
  bit     long_hold = 1'b0;
  longint cycles = 0;
  int     sent = 0;

  toboggan_watershed_segmenter u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata, out_tlast);

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 4);
      if (long_hold) begin
        gap = 400;
        long_hold = 1'b0;
      end
      repeat (gap) @(negedge clk) out_tready <= 1'b0;
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_item(bit kind, bit [7:0] pv);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pv;
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(kind, pv);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    if (sb.maybe_busy) repeat (NPIX + 100 * sb.eff_w() * sb.eff_h() + 1000) @(posedge clk);
    else repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [8:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    sb.apply_reg(idx, val);
  endtask

  task automatic load_pixels(int count, int style);
    int w;
    w = sb.eff_w();
    for (int p = 0; p < count; p++) begin
      case (style)
        0:       send_item(KIND_LOAD, $urandom_range(0, 255));
        1:       send_item(KIND_LOAD, ((p % w) * 37 + (p / w) * 23) & 8'hFF);
        default: send_item(KIND_LOAD, ($urandom_range(0, 3) * 85) & 8'hFF);
      endcase
    end
  endtask

  task automatic read_pixels(int count);
    for (int p = 0; p < count; p++) send_item(KIND_READ, $urandom_range(0, 255));
  endtask

  initial begin
    int w, h, total, n;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    read_pixels(2);
    write_reg(CFG_WIDTH, 9'd1);
    write_reg(CFG_HEIGHT, 9'd1);
    send_item(KIND_LOAD, 8'd0);
    read_pixels(2);

    write_reg(CFG_WIDTH, 9'd0);
    write_reg(CFG_HEIGHT, 9'd3);
    write_reg(CFG_LINES, 9'd1);
    send_item(KIND_LOAD, 8'd255);
    send_item(KIND_LOAD, 8'd0);
    send_item(KIND_LOAD, 8'd255);
    read_pixels(3);

    write_reg(CFG_WIDTH, 9'd4);
    write_reg(CFG_HEIGHT, 9'd4);
    load_pixels(16, 2);
    read_pixels(5);
    load_pixels(16, 0);
    long_hold = 1'b1;
    read_pixels(16);

    write_reg(CFG_WIDTH, 9'd3);
    write_reg(CFG_HEIGHT, 9'd3);
    load_pixels(4, 0);
    write_reg(CFG_UNUSED, 9'h1FF);
    load_pixels(9, 1);
    read_pixels(9);

    write_reg(CFG_LINES, 9'd0);
    write_reg(CFG_WIDTH, 9'd511);
    write_reg(CFG_HEIGHT, 9'd1);
    load_pixels(256, 1);
    read_pixels(24);

    n = 0;
    while (n < 9 && sent < 420) begin
      w = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 7);
      h = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 7);
      total = w * h;
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      write_reg(CFG_LINES, $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) read_pixels($urandom_range(1, 3));
      load_pixels(total, $urandom_range(0, 2));
      if (n == 4) long_hold = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        read_pixels($urandom_range(1, total));
      end else begin
        read_pixels(total);
        if ($urandom_range(0, 2) == 0) read_pixels($urandom_range(1, 3));
      end
      n++;
    end

    drain();
    repeat (200) @(posedge clk);
    $display("%0d input transfers, %0d images segmented, %0d output transfers checked",
             sent, sb.images, sb.results);
    $display("image sizes 1x1 to 256x1 with border lines on and off, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/tws_pkg.sv
design/tws_ram.sv
design/tws_isqrt.sv
design/toboggan_watershed_segmenter.sv
dv/toboggan_watershed_segmenter_tb.sv
